@@ src/swrm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared widths, constants and control types of the sliding-window rms meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 24;
  localparam int CHAN_W   = 3;
  localparam int LEVEL_W  = SAMPLE_W - 1;
  localparam int CFG_W    = 15;

  // a squared sample never exceeds 2^46, so 47 bits hold it
  localparam int SQ_W = 2 * SAMPLE_W - 1;

  // window length after reset (300 ms at 48 kHz)
  localparam int WINDOW_RESET = 14400;

  // largest level code, a full-scale root saturates to it
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  // commands from the sample sequencer to the root unit
  typedef struct packed {
    logic start;
    logic take;
  } swrm_root_ctl_t;

endpackage : swrm_pkg
`default_nettype wire

@@ src/swrm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule : swrm_ram
`default_nettype wire

@@ src/swrm_root.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_root
// Mean and root unit: restoring divide of the square sum by the fill count,
// one quotient bit per cycle, then a digit-by-digit integer square root,
// one root bit per cycle. The result saturates to the largest level code.
// ----------------------------------------------------------------------------
module swrm_root
  import swrm_pkg::*;
#(
  parameter int SUM_W = 61,
  parameter int DIV_W = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire swrm_root_ctl_t       ctl,
  input  wire logic [SUM_W-1:0]     dividend,
  input  wire logic [DIV_W-1:0]     divisor,
  output logic                      done,
  output logic      [LEVEL_W-1:0]   level
);

  localparam int RW    = SUM_W + (SUM_W % 2);
  localparam int HW    = RW / 2;
  localparam int CNT_W = $clog2(SUM_W + 1);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_DIV  = 4'b0010,
    R_SQRT = 4'b0100,
    R_DONE = 4'b1000
  } root_state_t;

  root_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] q_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] d_r;
  logic [RW-1:0]    sx_r;
  logic [HW-1:0]    srem_r;
  logic [HW-1:0]    root_r;

  // divide step
  logic [DIV_W:0]   rem_sh;
  logic             div_ge;
  logic [DIV_W:0]   rem_sub;

  assign rem_sh  = {rem_r, q_r[SUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, d_r};
  assign rem_sub = rem_sh - {1'b0, d_r};

  // root step
  logic [HW+1:0]    srem_sh;
  logic [HW+1:0]    trial;
  logic             sq_ge;
  logic [HW+1:0]    srem_sub;

  assign srem_sh  = {srem_r, sx_r[RW-1:RW-2]};
  assign trial    = {root_r, 2'b01};
  assign sq_ge    = srem_sh >= trial;
  assign srem_sub = srem_sh - trial;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      R_IDLE: if (ctl.start) state_nxt = R_DIV;
      R_DIV:  if (cnt_r == CNT_W'(1)) state_nxt = R_SQRT;
      R_SQRT: if (cnt_r == CNT_W'(1)) state_nxt = R_DONE;
      R_DONE: if (ctl.take) state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        R_IDLE: cnt_r <= CNT_W'(SUM_W);
        R_DIV:  cnt_r <= (cnt_r == CNT_W'(1)) ? CNT_W'(HW) : cnt_r - CNT_W'(1);
        R_SQRT: cnt_r <= cnt_r - CNT_W'(1);
        R_DONE: cnt_r <= cnt_r;
        default: cnt_r <= '0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      R_IDLE: begin
        q_r   <= dividend;
        d_r   <= divisor;
        rem_r <= '0;
      end
      R_DIV: begin
        rem_r <= div_ge ? DIV_W'(rem_sub) : DIV_W'(rem_sh);
        q_r   <= {q_r[SUM_W-2:0], div_ge};
        // last quotient bit: hand the quotient to the root stage
        if (cnt_r == CNT_W'(1)) begin
          sx_r   <= RW'({q_r[SUM_W-2:0], div_ge});
          srem_r <= '0;
          root_r <= '0;
        end
      end
      R_SQRT: begin
        srem_r <= sq_ge ? HW'(srem_sub) : HW'(srem_sh);
        root_r <= {root_r[HW-2:0], sq_ge};
        sx_r   <= {sx_r[RW-3:0], 2'b00};
      end
      R_DONE: begin
        root_r <= root_r;
      end
      default: begin
        root_r <= root_r;
      end
    endcase
  end

  // saturated result
  assign done  = (state_r == R_DONE);
  assign level = (root_r > HW'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(root_r);

endmodule : swrm_root
`default_nettype wire

@@ src/sliding_window_rms_meter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_rms_meter_unit
// Multi-channel moving-window rms level meter with per-channel sample ring.
// ----------------------------------------------------------------------------
// A sample request steps through reading the channel state memory, reading
// the oldest sample from the ring memory, writing the new sample and writing
// back the updated square sum, position and fill count. A sample marked
// block_end then runs the mean and root unit, one divide or root bit per
// cycle, before the level is offered. The ring is never cleared: until a
// channel's window has filled, the entry being overwritten counts as zero, so
// reset and window writes take effect at once.
// A channel at or above MAX_CHANNELS is dropped with no result.
module sliding_window_rms_meter_unit
  import swrm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_WINDOW   = 16384
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // sample requests
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic [CHAN_W-1:0]   in_channel,
  input  wire logic                in_block_end,
  // level results
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [LEVEL_W-1:0]       out_rms_level,
  output logic [CHAN_W-1:0]        out_rms_channel,
  // window length register
  input  wire logic                cfg_we,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  localparam int CH_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_XW   = (CH_AW > CHAN_W) ? CH_AW : CHAN_W;
  localparam int POS_W   = $clog2(MAX_WINDOW);
  localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SQ_W + $clog2(MAX_WINDOW);
  localparam int CS_W    = SUM_W + POS_W + FILL_W;
  localparam int RING_D  = MAX_CHANNELS * MAX_WINDOW;
  localparam int RING_AW = $clog2(RING_D);
  localparam int WIN_RST = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  localparam logic [RING_AW-1:0] WIN_STRIDE = RING_AW'(MAX_WINDOW);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CREAD = 5'b00010,
    S_RREAD = 5'b00100,
    S_UPD   = 5'b01000,
    S_ROOT  = 5'b10000
  } seq_state_t;

  // effective window: zero acts as one, large values clamp
  function automatic logic [FILL_W-1:0] eff_window(input logic [CFG_W-1:0] w);
    logic [FILL_W-1:0] r;
    if (w == '0) begin
      r = FILL_W'(1);
    end else if (32'(w) > MAX_WINDOW) begin
      r = FILL_W'(MAX_WINDOW);
    end else begin
      r = FILL_W'(w);
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] mag_of(input logic signed [SAMPLE_W-1:0] s);
    return s[SAMPLE_W-1] ? SAMPLE_W'(-s) : SAMPLE_W'(s);
  endfunction

  seq_state_t            state_r, state_nxt;
  logic [FILL_W-1:0]     win_r;
  logic [MAX_CHANNELS-1:0] chan_vld_r;

  logic signed [SAMPLE_W-1:0] smp_r;
  logic [CH_AW-1:0]      ch_r;
  logic                  last_r;
  logic                  chv_r;
  logic [POS_W-1:0]      pos_r;
  logic [FILL_W-1:0]     fill_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SQ_W-1:0]       new_sq_r;
  logic [SQ_W-1:0]       old_sq_r;
  logic [RING_AW-1:0]    ring_addr_r;

  logic                  out_valid_r;
  logic [LEVEL_W-1:0]    out_level_r;
  logic [CHAN_W-1:0]     out_chan_r;

  // input channel decode
  logic [CH_XW-1:0]      in_ch_ext;
  logic [CH_AW-1:0]      in_ch_idx;
  logic                  in_ch_ok;
  logic                  in_acc;

  assign in_ch_ext = CH_XW'(in_channel);
  assign in_ch_idx = in_ch_ext[CH_AW-1:0];
  assign in_ch_ok  = 32'(in_channel) < MAX_CHANNELS;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  // channel state memory
  logic [CS_W-1:0]       cs_rdata;
  logic [CS_W-1:0]       cs_cur;
  logic [CS_W-1:0]       cs_wdata;
  logic                  cs_we;

  // ring memory
  logic [SAMPLE_W-1:0]   rg_rdata;
  logic                  rg_we;
  logic [RING_AW-1:0]    ring_addr_nxt;

  // channel state unpack, position guard and ring address
  logic [SUM_W-1:0]      cur_sum;
  logic [POS_W-1:0]      cur_pos_raw;
  logic [POS_W-1:0]      cur_pos;
  logic [FILL_W-1:0]     cur_fill;

  assign cs_cur      = chv_r ? cs_rdata : '0;
  assign cur_sum     = cs_cur[CS_W-1 -: SUM_W];
  assign cur_pos_raw = cs_cur[FILL_W +: POS_W];
  assign cur_fill    = cs_cur[FILL_W-1:0];
  assign cur_pos     = (FILL_W'(cur_pos_raw) >= win_r) ? '0 : cur_pos_raw;
  assign ring_addr_nxt = RING_AW'(ch_r) * WIN_STRIDE + RING_AW'(cur_pos);

  // squares of the new and the overwritten sample
  logic [SAMPLE_W-1:0]   new_mag;
  logic [SAMPLE_W-1:0]   old_mag;
  logic [2*SAMPLE_W-1:0] new_prod;
  logic [2*SAMPLE_W-1:0] old_prod;
  logic                  ring_full;

  assign ring_full = (fill_r >= win_r);
  assign new_mag   = mag_of(smp_r);
  assign old_mag   = ring_full ? mag_of(rg_rdata) : '0;
  assign new_prod  = new_mag * new_mag;
  assign old_prod  = old_mag * old_mag;

  // update of sum, position and fill
  logic [SUM_W-1:0]      sum_nxt;
  logic [FILL_W-1:0]     pos_inc;
  logic [POS_W-1:0]      pos_nxt;
  logic [FILL_W-1:0]     fill_nxt;

  assign sum_nxt  = sum_r - SUM_W'(old_sq_r) + SUM_W'(new_sq_r);
  assign pos_inc  = FILL_W'(pos_r) + FILL_W'(1);
  assign pos_nxt  = (pos_inc >= win_r) ? '0 : POS_W'(pos_inc);
  assign fill_nxt = (fill_r < win_r) ? fill_r + FILL_W'(1) : fill_r;
  assign cs_wdata = {sum_nxt, pos_nxt, fill_nxt};
  assign cs_we    = (state_r == S_UPD);
  assign rg_we    = (state_r == S_RREAD);

  // root unit hookup
  swrm_root_ctl_t        root_ctl;
  logic                  root_done;
  logic [LEVEL_W-1:0]    root_level;
  logic                  out_free;

  assign out_free = !out_valid_r || out_ready;
  // start, take
  assign root_ctl = {(state_r == S_UPD) && last_r,
                     (state_r == S_ROOT) && root_done && out_free};

  swrm_ram #(
    .WIDTH (CS_W),
    .DEPTH (MAX_CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (ch_r),
    .wdata (cs_wdata),
    .raddr (in_ch_idx),
    .rdata (cs_rdata)
  );

  swrm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_D)
  ) u_ring_ram (
    .clk   (clk),
    .we    (rg_we),
    .waddr (ring_addr_r),
    .wdata (smp_r),
    .raddr (ring_addr_nxt),
    .rdata (rg_rdata)
  );

  swrm_root #(
    .SUM_W (SUM_W),
    .DIV_W (FILL_W)
  ) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (root_ctl),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .done     (root_done),
    .level    (root_level)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_ch_ok) state_nxt = S_CREAD;
      S_CREAD: state_nxt = S_RREAD;
      S_RREAD: state_nxt = S_UPD;
      S_UPD:   state_nxt = last_r ? S_ROOT : S_IDLE;
      S_ROOT:  if (root_ctl.take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers: state, window, channel valid bits, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= FILL_W'(WIN_RST);
      chan_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      priority if (cfg_we) begin
        win_r      <= eff_window(cfg_wdata);
        chan_vld_r <= '0;
      end else if (cs_we) begin
        chan_vld_r[ch_r] <= 1'b1;
      end
      priority if (root_ctl.take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r  <= in_sample;
      ch_r   <= in_ch_idx;
      last_r <= in_block_end;
      chv_r  <= chan_vld_r[in_ch_idx];
    end
    if (state_r == S_CREAD) begin
      sum_r       <= cur_sum;
      pos_r       <= cur_pos;
      fill_r      <= cur_fill;
      ring_addr_r <= ring_addr_nxt;
      new_sq_r    <= SQ_W'(new_prod);
    end
    if (state_r == S_RREAD) begin
      old_sq_r <= SQ_W'(old_prod);
    end
    if (root_ctl.take) begin
      out_level_r <= root_level;
      out_chan_r  <= CHAN_W'(ch_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rms_level   = out_level_r;
  assign out_rms_channel = out_chan_r;

endmodule : sliding_window_rms_meter_unit
`default_nettype wire
